// ----- rtl/lif_pkg.sv -----
// ----------------------------------------------------------------------------
// lif_pkg: shared types and constants for the LIF population tick block
// Payload structs, controller state enum, controller/datapath command bundle.
// ----------------------------------------------------------------------------
package lif_pkg;

    localparam int Neurons     = 8;
    localparam int NeuronCount = 5 * Neurons;
    localparam int DriveCount  = 3 * Neurons;
    localparam int NW          = $clog2(NeuronCount);
    localparam int DW          = $clog2(DriveCount);
    localparam int IW          = $clog2(Neurons);
    // population count width, fits 0..2N
    localparam int CW          = $clog2(2 * Neurons + 1);
    localparam int OutDen      = 2 * Neurons * Neurons;

    localparam logic [15:0] DecayReset  = 16'd62341;
    localparam logic [3:0]  RefracReset = 4'd2;
    localparam logic [14:0] BthrReset   = 15'd2867;
    localparam logic [15:0] FireLevel   = 16'sd4096;

    localparam logic [1:0] CfgDecay  = 2'd0;
    localparam logic [1:0] CfgRefrac = 2'd1;
    localparam logic [1:0] CfgBthr   = 2'd2;
    localparam logic [1:0] CfgBden   = 2'd3;

    localparam logic ReqWrite = 1'b0;
    localparam logic ReqTick  = 1'b1;

    typedef struct packed {
        logic        req_type;
        logic [1:0]  population;
        logic [2:0]  neuron_index;
        logic signed [15:0] drive_value;
    } t_in;

    typedef struct packed {
        logic [3:0]  evidence_spikes;
        logic [3:0]  reliability_spikes;
        logic [3:0]  bias_spikes;
        logic [4:0]  output_spikes;
        logic [7:0]  bias_detect_mask;
        logic [31:0] total_spike_count;
        logic [31:0] bias_detect_count;
    } t_out;

    typedef enum logic [2:0] {
        ST_IDLE, ST_READ, ST_MUL, ST_WB, ST_ODRV, ST_DONE
    } t_state;

    typedef struct packed {
        logic          clr;      // clear counts at tick start
        logic          rd;       // issue memory read of neuron idx
        logic          mul;      // register products
        logic          wb;       // write back neuron and count
        logic          odrv;     // compute output drive
        logic          fin;      // load result register
        logic [NW-1:0] idx;
    } t_cmd;

endpackage

// ----- rtl/lif_population_tick.sv -----
// ----------------------------------------------------------------------------
// lif_population_tick: leaky integrate-and-fire neuron array, four populations
// A tick visits all 5N neurons in turn from the neuron store, each through
// read, multiply and write-back steps; after the first 3N neurons it computes
// the shared output drive once, and after the last neuron it posts the result.
// One tick is in flight at a time; the result sits in an output register, so
// a write may be taken while it waits. A tick that finishes while an older
// result is still stalled holds its last state until that result is taken.
// ----------------------------------------------------------------------------
module lif_population_tick import lif_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  t_in         i_data,
    output logic        o_valid,
    input  logic        i_stall,
    output t_out        o_data,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    logic [15:0] r_decay;
    logic [3:0]  r_refrac;
    logic [14:0] r_bthr;
    logic        r_bden, r_ovld;
    logic        w_busy, w_acc, w_wr;
    t_cmd        w_cmd;
    logic [DW-1:0] w_waddr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_decay  <= DecayReset;
            r_refrac <= RefracReset;
            r_bthr   <= BthrReset;
            r_bden   <= 1'b1;
            r_ovld   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CfgDecay:  r_decay  <= i_cfg_data;
                    CfgRefrac: r_refrac <= i_cfg_data[3:0];
                    CfgBthr:   r_bthr   <= i_cfg_data[14:0];
                    CfgBden:   r_bden   <= i_cfg_data[0];
                    default:   ;
                endcase
            end
            if (w_cmd.fin) r_ovld <= 1'b1;
            else if (r_ovld && !i_stall) r_ovld <= 1'b0;
        end
    end

    assign o_stall = w_busy;
    assign w_acc   = i_valid && !w_busy;
    assign w_wr    = w_acc && (i_data.req_type == ReqWrite) && (i_data.population != 2'd3)
                     && (32'(i_data.neuron_index) < Neurons);
    assign w_waddr = DW'(32'(i_data.population) * Neurons + 32'(i_data.neuron_index));
    assign o_valid = r_ovld;

    lif_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_acc && (i_data.req_type == ReqTick)),
        .i_res_free (!r_ovld || !i_stall),
        .o_busy     (w_busy),
        .o_cmd      (w_cmd)
    );

    lif_dpath u_dpath (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (w_cmd),
        .i_wr_en   (w_wr),
        .i_wr_addr (w_waddr),
        .i_wr_data (i_data.drive_value),
        .i_decay   (r_decay),
        .i_refrac  (r_refrac),
        .i_bthr    (r_bthr),
        .i_bden    (r_bden),
        .o_res     (o_data)
    );
endmodule

// ----- rtl/lif_ctrl.sv -----
// ----------------------------------------------------------------------------
// lif_ctrl: tick sequencer
// Walks all neurons through read, multiply and write-back steps.
// ----------------------------------------------------------------------------
module lif_ctrl import lif_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  logic i_res_free,
    output logic o_busy,
    output t_cmd o_cmd
);
    t_state r_state, n_state;
    logic [NW-1:0] r_idx, n_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        o_cmd   = '0;
        o_cmd.idx = r_idx;
        o_busy  = (r_state != ST_IDLE);
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    o_cmd.clr = 1'b1;
                    n_idx     = '0;
                    n_state   = ST_READ;
                end
            end
            ST_READ: begin
                o_cmd.rd = 1'b1;
                n_state  = ST_MUL;
            end
            ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = ST_WB;
            end
            ST_WB: begin
                o_cmd.wb = 1'b1;
                if (r_idx == NW'(NeuronCount - 1)) begin
                    n_state = ST_DONE;
                end else begin
                    n_idx = r_idx + NW'(1);
                    if (r_idx == NW'(3 * Neurons - 1)) n_state = ST_ODRV;
                    else n_state = ST_READ;
                end
            end
            ST_ODRV: begin
                o_cmd.odrv = 1'b1;
                n_state    = ST_READ;
            end
            ST_DONE: begin
                if (i_res_free) begin
                    o_cmd.fin = 1'b1;
                    n_state   = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end
endmodule

// ----- rtl/lif_dpath.sv -----
// ----------------------------------------------------------------------------
// lif_dpath: neuron memories, leak arithmetic and spike counters
// Each neuron is read, multiplied, written back; output drive once per tick.
// ----------------------------------------------------------------------------
module lif_dpath import lif_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    input  logic        i_wr_en,
    input  logic [DW-1:0] i_wr_addr,
    input  logic [15:0] i_wr_data,
    input  logic [15:0] i_decay,
    input  logic [3:0]  i_refrac,
    input  logic [14:0] i_bthr,
    input  logic        i_bden,
    output t_out        o_res
);
    // membrane/refractory: valid bits cover reset state
    logic [15:0] r_mem  [NeuronCount];
    logic [3:0]  r_ref  [NeuronCount];
    logic [NeuronCount-1:0] r_nvld;
    logic [15:0] r_drv  [DriveCount];
    logic [DriveCount-1:0]  r_dvld;

    logic [15:0] r_m, r_d, r_od;
    logic [3:0]  r_rf;
    logic        r_mv, r_dv, r_rv;
    logic signed [33:0] r_p0, r_p1;
    logic [CW-1:0] r_e, r_r, r_b, r_o;
    logic [7:0]  r_mask;
    logic [31:0] r_stot, r_dtot;

    logic [IW-1:0]  w_nin;
    logic [1:0]     w_pop;
    logic signed [15:0] w_m, w_d;
    logic [3:0]     w_rf;
    logic signed [34:0] w_acc;
    logic signed [18:0] w_sh;
    logic signed [15:0] w_new;
    logic           w_fire;
    logic           w_det;
    logic signed [31:0] w_num, w_q;
    logic signed [15:0] w_odrv;

    assign w_pop = (i_cmd.idx < NW'(Neurons)) ? 2'd0 :
                   (i_cmd.idx < NW'(2 * Neurons)) ? 2'd1 :
                   (i_cmd.idx < NW'(3 * Neurons)) ? 2'd2 : 2'd3;
    assign w_nin = IW'(i_cmd.idx - NW'(w_pop) * NW'(Neurons));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nvld <= '0;
            r_dvld <= '0;
        end else begin
            if (i_wr_en) r_dvld[i_wr_addr] <= 1'b1;
            if (i_cmd.wb) r_nvld[i_cmd.idx] <= 1'b1;
        end
        if (i_wr_en) r_drv[i_wr_addr] <= i_wr_data;
        if (i_cmd.wb) begin
            r_mem[i_cmd.idx] <= w_new;
            r_ref[i_cmd.idx] <= w_rf;
        end
        if (i_cmd.rd) begin
            r_m  <= r_mem[i_cmd.idx];
            r_rf <= r_ref[i_cmd.idx];
            r_mv <= r_nvld[i_cmd.idx];
            if (w_pop != 2'd3) begin
                r_d  <= r_drv[DW'(i_cmd.idx)];
                r_dv <= r_dvld[DW'(i_cmd.idx)];
            end else begin
                r_d  <= r_od;
                r_dv <= 1'b1;
            end
        end
    end

    assign w_m  = r_mv ? $signed(r_m) : 16'sd0;
    assign w_d  = r_dv ? $signed(r_d) : 16'sd0;

    // signed potential and drive times unsigned weights
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_p0 <= w_m * $signed({1'b0, i_decay});
            r_p1 <= w_d * $signed({1'b0, 17'd65536 - {1'b0, i_decay}});
            r_rv <= r_mv && (r_rf != 4'd0);
        end
    end

    assign w_acc = 35'(r_p0) + 35'(r_p1) + 35'sd32768;
    assign w_sh  = 19'(w_acc >>> 16);
    always_comb begin
        if (w_sh > 19'sd32767) w_new = 16'sd32767;
        else if (w_sh < -19'sd32768) w_new = -16'sd32768;
        else w_new = 16'(w_sh);
        w_fire = 1'b0;
        w_rf   = 4'd0;
        if (r_rv) begin
            w_new = w_m;
            w_rf  = r_rf - 4'd1;
        end else if (w_new >= $signed(FireLevel)) begin
            w_new  = '0;
            w_rf   = i_refrac;
            w_fire = 1'b1;
        end
    end
    assign w_det = w_fire && (w_pop == 2'd2) && i_bden && (w_d > $signed({1'b0, i_bthr}));

    // output drive: round(4096*(2er - bN) / (2N^2)); N^2 a power of two here
    assign w_num = 32'(4096) * (32'(2) * 32'(r_e) * 32'(r_r) - 32'(r_b) * 32'(Neurons))
                   + 32'(OutDen / 2);
    assign w_q   = w_num >>> $clog2(OutDen);
    assign w_odrv = (w_q > 32'sd32767) ? 16'sd32767 :
                    (w_q < -32'sd32768) ? -16'sd32768 : 16'(w_q);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stot <= '0;
            r_dtot <= '0;
        end else begin
            if (i_cmd.wb && w_fire) r_stot <= r_stot + 32'd1;
            if (i_cmd.wb && w_det)  r_dtot <= r_dtot + 32'd1;
        end
        if (i_cmd.clr) begin
            r_e <= '0; r_r <= '0; r_b <= '0; r_o <= '0; r_mask <= '0;
        end
        if (i_cmd.wb && w_fire) begin
            case (w_pop)
                2'd0: r_e <= r_e + CW'(1);
                2'd1: r_r <= r_r + CW'(1);
                2'd2: r_b <= r_b + CW'(1);
                default: r_o <= r_o + CW'(1);
            endcase
        end
        if (i_cmd.wb && w_det && (32'(w_nin) < 32'd8)) r_mask[3'(w_nin)] <= 1'b1;
        if (i_cmd.odrv) r_od <= w_odrv;
        if (i_cmd.fin) begin
            o_res.evidence_spikes    <= 4'(r_e);
            o_res.reliability_spikes <= 4'(r_r);
            o_res.bias_spikes        <= 4'(r_b);
            o_res.output_spikes      <= 5'(r_o);
            o_res.bias_detect_mask   <= r_mask;
            o_res.total_spike_count  <= r_stot;
            o_res.bias_detect_count  <= r_dtot;
        end
    end
endmodule

// ----- sim/tb.sv -----
// ----------------------------------------------------------------------------
// tb: self-checking bench for lif_population_tick
// Drives drive writes and ticks under random idling, predicts every tick
// result with an in-bench LIF model and compares each result beat by field.
// ----------------------------------------------------------------------------
module tb import lif_pkg::*; ();

    class lif_scoreboard;
        logic [15:0]        decay;
        logic [3:0]         refrac;
        logic [14:0]        bthr;
        logic               bden;
        logic signed [15:0] membrane [NeuronCount];
        logic [3:0]         refcnt [NeuronCount];
        logic signed [15:0] drive [DriveCount];
        logic [31:0]        spike_total;
        logic [31:0]        detect_total;
        t_out               pending [$];
        int                 errors;

        function new();
            decay = DecayReset;
            refrac = RefracReset;
            bthr = BthrReset;
            bden = 1'b1;
            foreach (membrane[i]) begin
                membrane[i] = '0;
                refcnt[i] = '0;
            end
            foreach (drive[i]) drive[i] = '0;
            spike_total = '0;
            detect_total = '0;
            errors = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [15:0] val);
            case (idx)
                CfgDecay:  decay = val;
                CfgRefrac: refrac = val[3:0];
                CfgBthr:   bthr = val[14:0];
                default:   bden = val[0];
            endcase
        endfunction

        // floor division toward minus infinity, den > 0
        function longint floor_quot(longint x, longint den);
            if (x >= 0) return x / den;
            return -((-x + den - 1) / den);
        endfunction

        function logic signed [15:0] clamp16(longint v);
            if (v > 32767) return 16'sh7fff;
            if (v < -32768) return 16'sh8000;
            return v[15:0];
        endfunction

        function bit leak_neuron(int idx, logic signed [15:0] drv);
            longint acc;
            if (refcnt[idx] != 0) begin
                refcnt[idx] = refcnt[idx] - 4'd1;
                return 0;
            end
            acc = longint'(membrane[idx]) * longint'({1'b0, decay})
                + longint'(drv) * (65536 - longint'({1'b0, decay}));
            membrane[idx] = clamp16(floor_quot(acc + 32768, 65536));
            if (membrane[idx] >= $signed(FireLevel)) begin
                membrane[idx] = '0;
                refcnt[idx] = refrac;
                return 1;
            end
            return 0;
        endfunction

        function void note_beat(t_in it);
            int ev, rel, bia, outc;
            logic [7:0] mask;
            longint num;
            logic signed [15:0] odrv;
            t_out res;
            if (it.req_type == ReqWrite) begin
                if (it.population < 3 && it.neuron_index < Neurons)
                    drive[it.population * Neurons + it.neuron_index] = it.drive_value;
                return;
            end
            ev = 0; rel = 0; bia = 0; outc = 0; mask = '0;
            for (int i = 0; i < Neurons; i++) ev += leak_neuron(i, drive[i]);
            for (int i = 0; i < Neurons; i++)
                rel += leak_neuron(Neurons + i, drive[Neurons + i]);
            for (int i = 0; i < Neurons; i++) begin
                if (leak_neuron(2 * Neurons + i, drive[2 * Neurons + i])) begin
                    bia++;
                    if (bden && longint'(drive[2 * Neurons + i]) > longint'({1'b0, bthr})) begin
                        detect_total++;
                        if (i < 8) mask[i] = 1'b1;
                    end
                end
            end
            num = 4096 * (2 * longint'(ev) * rel - longint'(bia) * Neurons);
            odrv = clamp16(floor_quot(num + OutDen / 2, OutDen));
            for (int i = 0; i < 2 * Neurons; i++)
                outc += leak_neuron(3 * Neurons + i, odrv);
            spike_total += ev + rel + bia + outc;
            res.evidence_spikes = ev[3:0];
            res.reliability_spikes = rel[3:0];
            res.bias_spikes = bia[3:0];
            res.output_spikes = outc[4:0];
            res.bias_detect_mask = mask;
            res.total_spike_count = spike_total;
            res.bias_detect_count = detect_total;
            pending.push_back(res);
        endfunction

        function void check_beat(t_out got);
            t_out exp_r;
            if (pending.size() == 0) begin
                $error("unexpected result beat %h", got);
                errors++;
                return;
            end
            exp_r = pending.pop_front();
            if (got.evidence_spikes !== exp_r.evidence_spikes) begin
                $error("evidence_spikes exp %0d got %0d", exp_r.evidence_spikes,
                       got.evidence_spikes); errors++;
            end
            if (got.reliability_spikes !== exp_r.reliability_spikes) begin
                $error("reliability_spikes exp %0d got %0d", exp_r.reliability_spikes,
                       got.reliability_spikes); errors++;
            end
            if (got.bias_spikes !== exp_r.bias_spikes) begin
                $error("bias_spikes exp %0d got %0d", exp_r.bias_spikes,
                       got.bias_spikes); errors++;
            end
            if (got.output_spikes !== exp_r.output_spikes) begin
                $error("output_spikes exp %0d got %0d", exp_r.output_spikes,
                       got.output_spikes); errors++;
            end
            if (got.bias_detect_mask !== exp_r.bias_detect_mask) begin
                $error("bias_detect_mask exp %h got %h", exp_r.bias_detect_mask,
                       got.bias_detect_mask); errors++;
            end
            if (got.total_spike_count !== exp_r.total_spike_count) begin
                $error("total_spike_count exp %0d got %0d", exp_r.total_spike_count,
                       got.total_spike_count); errors++;
            end
            if (got.bias_detect_count !== exp_r.bias_detect_count) begin
                $error("bias_detect_count exp %0d got %0d", exp_r.bias_detect_count,
                       got.bias_detect_count); errors++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    t_in         i_data;
    logic        o_valid;
    logic        i_stall;
    t_out        o_data;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_index;
    logic [15:0] i_cfg_data;

    lif_scoreboard sb;
    int send_idle_pct;
    int recv_idle_pct;

    lif_population_tick dut (.*);

    always begin
        i_clk = 1'b0; #5;
        i_clk = 1'b1; #5;
    end

    // result side: random stall, check every accepted beat
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) sb.check_beat(o_data);
        i_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // valid stays high after the beat; wait_drained drops it
    task automatic send_beat(t_in it);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data <= it;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sb.note_beat(it);
    endtask

    task automatic write_drive(int pop, int idx, int val);
        t_in it;
        it.req_type = ReqWrite;
        it.population = pop[1:0];
        it.neuron_index = idx[2:0];
        it.drive_value = val[15:0];
        send_beat(it);
    endtask

    task automatic tick();
        t_in it;
        logic [31:0] rnd;
        rnd = $urandom;
        it = rnd[$bits(t_in)-1:0];
        it.req_type = ReqTick;
        send_beat(it);
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        // a tick may still be posting; writes cause no result
        repeat (140) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        sb.set_reg(idx, val);
    endtask

    task automatic random_beat();
        int r;
        t_in it;
        logic [31:0] rnd;
        r = $urandom_range(99);
        if (r < 45) tick();
        else begin
            rnd = $urandom;
            it = rnd[$bits(t_in)-1:0];
            it.req_type = ReqWrite;
            if (r < 90) begin
                it.population = 2'($urandom_range(2));
                // mostly drives near firing range, sometimes full width
                if ($urandom_range(3) != 0)
                    it.drive_value = 16'(int'($urandom_range(12000)) - 2000);
            end
            send_beat(it);
        end
    endtask

    task automatic random_phase(int n, int sidle, int ridle);
        send_idle_pct = sidle;
        recv_idle_pct = ridle;
        repeat (n) random_beat();
        send_idle_pct = 0;
        wait_drained();
    endtask

    initial begin
        sb = new();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_data = '0;
        i_stall = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = CfgDecay;
        i_cfg_data = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes, ignored writes, ticks at reset settings
        tick();
        write_drive(0, 0, 32767);
        write_drive(0, 7, -32768);
        write_drive(1, 3, 32767);
        write_drive(2, 0, 32767);
        write_drive(2, 1, 2867);
        write_drive(2, 2, 2868);
        write_drive(3, 5, 32767);
        write_drive(1, 7, 16'h5555);
        write_drive(2, 7, 16'haaaa);
        repeat (4) tick();
        wait_drained();
        // fast leak, zero refractory, threshold extreme
        write_reg(CfgDecay, 16'd0);
        write_reg(CfgRefrac, 4'd0);
        write_reg(CfgBthr, 16'h7fff);
        write_reg(CfgBden, 16'd1);
        for (int i = 0; i < Neurons; i++) write_drive(0, i, 32767);
        for (int i = 0; i < Neurons; i++) write_drive(1, i, 8000);
        repeat (3) tick();
        wait_drained();
        write_reg(CfgDecay, 16'hffff);
        write_reg(CfgRefrac, 4'd15);
        write_reg(CfgBthr, 16'd0);
        write_reg(CfgBden, 16'd0);
        repeat (2) tick();
        wait_drained();

        write_reg(CfgDecay, 16'd30000);
        write_reg(CfgRefrac, 4'd1);
        write_reg(CfgBthr, 16'd2000);
        write_reg(CfgBden, 16'd1);
        random_phase(180, 35, 48);
        write_reg(CfgDecay, DecayReset);
        write_reg(CfgRefrac, RefracReset);
        write_reg(CfgBthr, BthrReset);
        random_phase(180, 48, 35);
        write_reg(CfgDecay, 16'd8000);
        write_reg(CfgRefrac, 4'd0);
        write_reg(CfgBthr, 16'd4000);
        random_phase(190, 0, 0);

        if (sb.errors == 0 && sb.pending.size() == 0) $display("SCOREBOARD CLEAN");
        else $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        #8000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

// ----- filelist.f -----
rtl/lif_pkg.sv
rtl/lif_ctrl.sv
rtl/lif_dpath.sv
rtl/lif_population_tick.sv
sim/tb.sv
